>>> hdl/ggc_pkg.sv
// ggc_pkg: shared types, widths and codes of the greedy graph coloring block
// used by every module of the block; depends on nothing

package ggc_pkg;

   // default depth of the graph memory
   localparam int MAX_VERTICES_DEF = 32;

   // field widths
   localparam int ROW_W      = 32;
   localparam int COLOR_W    = 5;
   localparam int NUM_COLORS = 32;
   localparam int IDX_W      = 5;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 1'b1;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // one graph memory word: color of the vertex and its adjacency row
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ROW_W-1:0]   row;
   } graph_word_type;

   // access to the color class memory
   typedef struct packed {
      logic               clear;
      logic               re;
      logic [COLOR_W-1:0] raddr;
      logic               we;
      logic [COLOR_W-1:0] waddr;
      logic [ROW_W-1:0]   wdata;
   } class_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_RD,
      ST_SEED_WR,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_SCAN,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_FAIL
   } state_type;

endpackage

>>> hdl/ggc_graph_mem.sv
// ggc_graph_mem: graph memory, one word per vertex holding its adjacency row and color
// one write port, one read port with registered read data; depends on ggc_pkg

module ggc_graph_mem #(
   parameter int DEPTH = ggc_pkg::MAX_VERTICES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  ggc_pkg::graph_word_type wdata,
   input  logic                    re,
   input  logic [AW-1:0]           raddr,
   output ggc_pkg::graph_word_type rdata
);
   import ggc_pkg::*;

   graph_word_type mem [DEPTH];
   graph_word_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ggc_class_mem.sv
// ggc_class_mem: color class memory, one vertex set per color
// per-entry valid bits make a cleared entry read as empty; depends on ggc_pkg

module ggc_class_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  ggc_pkg::class_cmd_type       cmd,
   output logic [ggc_pkg::ROW_W-1:0]    rdata
);
   import ggc_pkg::*;

   logic [ROW_W-1:0]      mem [NUM_COLORS];
   logic [NUM_COLORS-1:0] valid_ff;
   logic [NUM_COLORS-1:0] valid_in;
   logic [ROW_W-1:0]      rdata_ff;
   logic                  rvalid_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   // valid bits: clear drops all classes, a write marks its class
   always_comb begin
      valid_in = cmd.clear ? '0 : valid_ff;
      if (cmd.we) begin
         valid_in[cmd.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // registered read, an empty class reads as zero
   always_ff @(posedge clock) begin
      if (cmd.re) begin
         rdata_ff  <= mem[cmd.raddr];
         rvalid_ff <= valid_ff[cmd.raddr];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

>>> hdl/ggc_ctrl.sv
// ggc_ctrl: sequencer for row loads, first-fit coloring attempts and result output
// drives the graph and color class memories; depends on ggc_pkg

module ggc_ctrl #(
   parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF,
   parameter int AW           = $clog2(MAX_VERTICES)
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_kind,
   input  logic [ggc_pkg::IDX_W-1:0]    req_row_index,
   input  logic [ggc_pkg::ROW_W-1:0]    req_row_bits,
   // configuration
   input  logic [ggc_pkg::CNT_W-1:0]    n_active,
   input  logic [ggc_pkg::CNT_W-1:0]    slot_count,
   // graph memory
   output logic                         g_we,
   output logic [AW-1:0]                g_waddr,
   output ggc_pkg::graph_word_type      g_wdata,
   output logic                         g_re,
   output logic [AW-1:0]                g_raddr,
   input  ggc_pkg::graph_word_type      g_rdata,
   // color class memory
   output ggc_pkg::class_cmd_type       cls_cmd,
   input  logic [ggc_pkg::ROW_W-1:0]    cls_rdata,
   // response side
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ggc_pkg::IDX_W-1:0]    rsp_vertex,
   output logic [ggc_pkg::COLOR_W-1:0]  rsp_color,
   output logic                         rsp_fail,
   output logic                         rsp_last
);
   import ggc_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     s_ff, s_in;
   logic [CNT_W-1:0]     u_ff, u_in;
   logic [COLOR_W-1:0]   c_ff, c_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                 rsp_fail_ff, rsp_fail_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire;
   logic [CNT_W-1:0]     attempts;
   logic                 rsp_free;
   logic                 hit;
   logic                 color_fits;
   logic                 u_done;
   logic                 u_is_s;
   logic                 last_attempt;
   logic                 last_vertex;
   logic                 row_in_range;
   logic [ROW_W-1:0]     u_bit;
   logic [ROW_W-1:0]     s_bit;

   // shared conditions
   assign req_fire     = req_tvalid && req_tready;
   assign attempts     = (slot_count < n_active) ? slot_count : n_active;
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign hit          = |(cls_rdata & row_ff);
   assign color_fits   = {1'b0, c_ff} < slot_count;
   assign u_done       = u_ff == n_active;
   assign u_is_s       = u_ff == s_ff;
   assign last_attempt = (s_ff + CNT_W'(1)) == attempts;
   assign last_vertex  = (u_ff + CNT_W'(1)) == n_active;
   assign row_in_range = 32'(req_row_index) < 32'(MAX_VERTICES);
   assign u_bit        = ROW_W'(1) << u_ff[IDX_W-1:0];
   assign s_bit        = ROW_W'(1) << s_ff[IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_kind == REQ_START) begin
               state_in = (attempts == '0) ? ST_FAIL : ST_SEED_RD;
            end
         end
         ST_SEED_RD:  state_in = ST_SEED_WR;
         ST_SEED_WR:  state_in = ST_ROW_RD;
         ST_ROW_RD: begin
            priority if (u_done) begin
               state_in = ST_OUT_RD;
            end else if (!u_is_s) begin
               state_in = ST_ROW_WAIT;
            end else begin
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_WAIT: state_in = ST_SCAN;
         ST_SCAN: begin
            priority if (hit) begin
               state_in = ST_SCAN;
            end else if (color_fits) begin
               state_in = ST_ROW_RD;
            end else if (last_attempt) begin
               state_in = ST_FAIL;
            end else begin
               state_in = ST_SEED_RD;
            end
         end
         ST_OUT_RD:   state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            if (rsp_free) begin
               state_in = last_vertex ? ST_IDLE : ST_OUT_RD;
            end
         end
         ST_FAIL: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs, memory accesses and datapath next values
   always_comb begin
      req_tready    = 1'b0;
      g_we          = 1'b0;
      g_waddr       = u_ff[AW-1:0];
      g_wdata       = '{color: c_ff, row: row_ff};
      g_re          = 1'b0;
      g_raddr       = u_ff[AW-1:0];
      cls_cmd       = '0;
      s_in          = s_ff;
      u_in          = u_ff;
      c_in          = c_ff;
      row_in        = row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_fail_in   = rsp_fail_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            g_waddr    = AW'(req_row_index);
            g_wdata    = '{color: '0, row: req_row_bits};
            s_in       = '0;
            if (req_fire && req_kind == REQ_LOAD && row_in_range) begin
               g_we = 1'b1;
            end
         end
         // fetch the start vertex row so its color can be written back
         ST_SEED_RD: begin
            g_re    = 1'b1;
            g_raddr = s_ff[AW-1:0];
         end
         // start vertex takes color 0, all other classes empty
         ST_SEED_WR: begin
            g_we          = 1'b1;
            g_waddr       = s_ff[AW-1:0];
            g_wdata       = '{color: '0, row: g_rdata.row};
            cls_cmd.clear = 1'b1;
            cls_cmd.we    = 1'b1;
            cls_cmd.waddr = '0;
            cls_cmd.wdata = s_bit;
            u_in          = '0;
         end
         ST_ROW_RD: begin
            if (!u_done) begin
               if (u_is_s) begin
                  u_in = u_ff + CNT_W'(1);
               end else begin
                  g_re = 1'b1;
               end
            end else begin
               u_in = '0;
            end
         end
         // latch the row and probe color 0
         ST_ROW_WAIT: begin
            row_in        = g_rdata.row;
            cls_cmd.re    = 1'b1;
            cls_cmd.raddr = '0;
            c_in          = '0;
         end
         // first-fit probe: lowest color whose class holds no neighbor
         ST_SCAN: begin
            priority if (hit) begin
               c_in          = c_ff + COLOR_W'(1);
               cls_cmd.re    = 1'b1;
               cls_cmd.raddr = c_ff + COLOR_W'(1);
            end else if (color_fits) begin
               g_we          = 1'b1;
               cls_cmd.we    = 1'b1;
               cls_cmd.waddr = c_ff;
               cls_cmd.wdata = cls_rdata | u_bit;
               u_in          = u_ff + CNT_W'(1);
            end else begin
               s_in = s_ff + CNT_W'(1);
            end
         end
         ST_OUT_RD: begin
            g_re = 1'b1;
         end
         ST_OUT_LD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = u_ff[IDX_W-1:0];
               rsp_color_in  = g_rdata.color;
               rsp_fail_in   = 1'b0;
               rsp_last_in   = last_vertex;
               u_in          = u_ff + CNT_W'(1);
            end
         end
         ST_FAIL: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_color_in  = '0;
               rsp_fail_in   = 1'b1;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      u_ff          <= u_in;
      c_ff          <= c_in;
      row_ff        <= row_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_fail_ff   <= rsp_fail_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_color  = rsp_color_ff;
   assign rsp_fail   = rsp_fail_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> hdl/greedy_graph_coloring.sv
// Load request: one per cycle back to back while the sequencer is idle; no response.
// Start request: each attempt has a seed read, a seed write and a skip of the start vertex,
// then per other vertex a row read, a row wait and a probe of each color class up to the first free one;
// a fitting attempt ends with a check state, then each vertex is read and emitted in turn
// (a failed run emits the fail response alone), and output waits while rsp_tready is low.
// Reset: 1 vertex and 32 slots, sequencer idle, color classes empty, rows undefined.

// greedy_graph_coloring: top level with configuration registers and stream ports
// depends on ggc_pkg, ggc_graph_mem, ggc_class_mem, ggc_ctrl

module greedy_graph_coloring #(
   parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // requests
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ggc_pkg::REQ_DATA_W-1:0]    req_tdata,  // row_index[4:0], row_bits[36:5]
   input  logic                              req_tuser,  // req_type
   // responses
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ggc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // vertex[4:0], color[9:5]
   output logic                              rsp_tuser,  // fail
   output logic                              rsp_tlast,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ggc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ggc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ggc_pkg::*;

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

   logic [CSR_DATA_W-1:0] vertex_count_ff, vertex_count_in;
   logic [CSR_DATA_W-1:0] slot_count_ff, slot_count_in;
   logic [CNT_W-1:0]      n_active;

   logic                  g_we;
   logic [AW-1:0]         g_waddr;
   graph_word_type        g_wdata;
   logic                  g_re;
   logic [AW-1:0]         g_raddr;
   graph_word_type        g_rdata;
   class_cmd_type         cls_cmd;
   logic [ROW_W-1:0]      cls_rdata;
   logic [IDX_W-1:0]      rsp_vertex;
   logic [COLOR_W-1:0]    rsp_color;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      slot_count_in   = slot_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_in = csr_data;
            CSR_SLOT_COUNT:   slot_count_in   = csr_data;
            default:          vertex_count_in = vertex_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= CSR_DATA_W'(1);
         slot_count_ff   <= CSR_DATA_W'(32);
      end else begin
         vertex_count_ff <= vertex_count_in;
         slot_count_ff   <= slot_count_in;
      end
   end

   // vertices in use, capped by the memory depth and the row width
   assign n_active = (32'(vertex_count_ff) > LIMIT) ? CNT_W'(LIMIT) : vertex_count_ff;

   ggc_graph_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_graph_mem (
      .clock (clock),
      .we    (g_we),
      .waddr (g_waddr),
      .wdata (g_wdata),
      .re    (g_re),
      .raddr (g_raddr),
      .rdata (g_rdata)
   );

   ggc_class_mem u_class_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (cls_cmd),
      .rdata (cls_rdata)
   );

   ggc_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .AW           (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_kind      (req_tuser),
      .req_row_index (req_tdata[IDX_W-1:0]),
      .req_row_bits  (req_tdata[IDX_W+ROW_W-1:IDX_W]),
      .n_active      (n_active),
      .slot_count    (slot_count_ff),
      .g_we          (g_we),
      .g_waddr       (g_waddr),
      .g_wdata       (g_wdata),
      .g_re          (g_re),
      .g_raddr       (g_raddr),
      .g_rdata       (g_rdata),
      .cls_cmd       (cls_cmd),
      .cls_rdata     (cls_rdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_vertex    (rsp_vertex),
      .rsp_color     (rsp_color),
      .rsp_fail      (rsp_tuser),
      .rsp_last      (rsp_tlast)
   );

   // response packing
   assign rsp_tdata = {(RSP_DATA_W - IDX_W - COLOR_W)'(0), rsp_color, rsp_vertex};

endmodule

>>> hdl/greedy_graph_coloring_chk.sv
// greedy_graph_coloring_chk: port-level checks on the coloring block
// bound to greedy_graph_coloring; depends on ggc_pkg

module greedy_graph_coloring_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ggc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import ggc_pkg::*;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a fail response closes the run
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("fail response without last");

   // a fail response carries vertex 0 and color 0
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("fail response with nonzero payload");

   // no request is taken while a run still has responses to come
   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a run");

endmodule

bind greedy_graph_coloring greedy_graph_coloring_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
